// ===== rtl/tkcs_pkg.sv =====
// Package for the top-k count selector: record types, item structs, cell
// control codes and the FSM state type. No dependencies.
`default_nettype none
package tkcs_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 32;
    localparam int KEEP_W   = 5;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] entry_count;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [CNT_W-1:0] out_count;
        logic             valid_res;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_rec;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REPLACE,
        OP_SHIFT
    } t_op;

    typedef struct packed {
        t_op  op;
        t_rec new_rec;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/top_k_count_selector_unit.sv =====
// Top level of the top-k count selector: command port, limit register,
// drain sequencer and the chain of tkcs_cell slots. Depends on tkcs_pkg.
//
// Usage:
//   An item transfers at a rising edge with start high and busy low.
//   command 0 offers (key, entry_count); it gives no result, so offers may
//   follow each other in every cycle. While fewer than keep_count records
//   are kept the record enters; otherwise it replaces the smallest kept
//   record only if its count is strictly greater. command 1 drains: busy
//   stays high until the last record is shifted out, and results appear
//   one per cycle on o_result with o_strobe, smallest count first; the
//   first is registered from the drain state that the transfer enters,
//   and the final one has last set. An empty store gives one result with
//   valid_res low in the cycle after the transfer, without raising busy.
//   The rate is set by the chain: each slot compares against the offered
//   count in parallel and moves one record per cycle during a drain.
//   i_cfg_we writes keep_count (0 acts as 1, above 16 as 16); write it only
//   while idle. Reset empties the store and sets keep_count to 16.
//   Results cannot be held off: each is marked by o_strobe for exactly one cycle.
`default_nettype none
module top_k_count_selector_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire tkcs_pkg::t_in_item               i_item,
    output logic                                  o_strobe,
    output tkcs_pkg::t_out_item                   o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [tkcs_pkg::KEEP_W-1:0]      i_cfg_wdata
);
    import tkcs_pkg::*;

    logic [KEEP_W-1:0] r_keep_count;
    t_state            r_state;
    t_state            n_state;
    logic              r_strobe;
    logic              n_strobe;
    t_out_item         r_out;
    t_out_item         n_out;
    t_cell_ctl         w_ctl;
    t_rec              w_rec   [0:CAPACITY];
    logic              w_used  [0:CAPACITY];
    logic              w_after [0:CAPACITY-1];
    logic              w_lt    [0:CAPACITY];
    logic [IDX_W-1:0]  w_lim_idx;
    logic              w_full;
    logic              w_accept;

    assign w_rec[CAPACITY]  = '0;
    assign w_used[CAPACITY] = 1'b0;
    assign w_lt[CAPACITY]   = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            tkcs_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_lo_rec   ((g == 0) ? w_rec[CAPACITY] : w_rec[(g == 0) ? 0 : g-1]),
                .i_lo_used  ((g == 0) ? 1'b0 : w_used[(g == 0) ? 0 : g-1]),
                .i_lo_after ((g == 0) ? 1'b0 : w_after[(g == 0) ? 0 : g-1]),
                .i_hi_rec   (w_rec[g+1]),
                .i_hi_used  (w_used[g+1]),
                .i_hi_lt    (w_lt[g+1]),
                .o_rec      (w_rec[g]),
                .o_used     (w_used[g]),
                .o_after    (w_after[g]),
                .o_lt       (w_lt[g])
            );
        end
    endgenerate

    always_comb begin
        if (r_keep_count == '0) begin
            w_lim_idx = '0;
        end else if (int'(r_keep_count) > CAPACITY) begin
            w_lim_idx = IDX_W'(CAPACITY - 1);
        end else begin
            w_lim_idx = IDX_W'(r_keep_count - KEEP_W'(1));
        end
    end

    // used slots form a prefix, so full means the slot at the limit is used
    assign w_full   = w_used[{1'b0, w_lim_idx}];
    assign busy     = (r_state == ST_DRAIN);
    assign w_accept = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_item.command == CMD_DRAIN && w_used[0]) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_used[1]) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.op      = OP_NONE;
        w_ctl.new_rec = '{key: i_item.key, count: i_item.entry_count};
        n_strobe      = 1'b0;
        n_out         = r_out;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_item.command == CMD_OFFER) begin
                        if (!w_full) begin
                            w_ctl.op = OP_INSERT;
                        end else if (i_item.entry_count > w_rec[0].count) begin
                            w_ctl.op = OP_REPLACE;
                        end
                    end else if (!w_used[0]) begin
                        n_strobe = 1'b1;
                        n_out    = '{out_key: '0, out_count: '0, valid_res: 1'b0,
                                     last: 1'b1};
                    end
                end
            end
            ST_DRAIN: begin
                w_ctl.op = OP_SHIFT;
                n_strobe = 1'b1;
                n_out    = '{out_key: w_rec[0].key, out_count: w_rec[0].count,
                             valid_res: 1'b1, last: !w_used[1]};
            end
            default: begin
                w_ctl.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_strobe     <= 1'b0;
            r_keep_count <= KEEP_RESET;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_keep_count <= i_cfg_wdata;
            end
        end
    end

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_used[0])
        else $error("drain running on an empty store");

    a_invalid_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.valid_res) |-> o_result.last)
        else $error("empty-drain result not marked last");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !w_used[1]) |=> (!w_used[0] && !busy))
        else $error("store not empty after final drain transfer");

    a_offer_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.command == CMD_OFFER) |=> !o_strobe)
        else $error("offer produced a result");

endmodule
`default_nettype wire

// ===== rtl/tkcs_cell.sv =====
// One slot of the sorted record chain; slot 0 holds the smallest rank.
// Depends on tkcs_pkg.
`default_nettype none
module tkcs_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tkcs_pkg::t_cell_ctl i_ctl,
    input  wire tkcs_pkg::t_rec     i_lo_rec,
    input  wire logic               i_lo_used,
    input  wire logic               i_lo_after,
    input  wire tkcs_pkg::t_rec     i_hi_rec,
    input  wire logic               i_hi_used,
    input  wire logic               i_hi_lt,
    output tkcs_pkg::t_rec          o_rec,
    output logic                    o_used,
    output logic                    o_after,
    output logic                    o_lt
);
    import tkcs_pkg::*;

    t_rec r_rec;
    t_rec n_rec;
    logic r_used;
    logic n_used;

    // at or past the insert point / strictly below the offered count
    assign o_after = !r_used || (r_rec.count >= i_ctl.new_rec.count);
    assign o_lt    = r_used && (r_rec.count < i_ctl.new_rec.count);
    assign o_rec   = r_rec;
    assign o_used  = r_used;

    always_comb begin
        n_rec  = r_rec;
        n_used = r_used;
        case (i_ctl.op)
            OP_INSERT: begin
                if (o_after) begin
                    if (i_lo_after) begin
                        n_rec  = i_lo_rec;
                        n_used = i_lo_used;
                    end else begin
                        n_rec  = i_ctl.new_rec;
                        n_used = 1'b1;
                    end
                end
            end
            OP_REPLACE: begin
                if (o_lt) begin
                    n_rec = i_hi_lt ? i_hi_rec : i_ctl.new_rec;
                end
            end
            OP_SHIFT: begin
                n_rec  = i_hi_rec;
                n_used = i_hi_used;
            end
            default: begin
                n_rec  = r_rec;
                n_used = r_used;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

endmodule
`default_nettype wire
